// File: design/wto_pkg.sv
// ----------------------------------------------------------------------------
// wto_pkg
// shared constants, types and the quarter-wave sine table of the wavetable
// oscillator
// ----------------------------------------------------------------------------
package wto_pkg;

    // table and sample rate
    localparam int WAVE_ENTRIES = 1024;
    localparam int SAMPLE_RATE  = 48000;
    localparam int TABLE_BITS   = $clog2(WAVE_ENTRIES + 1) - 1;
    localparam int QTR_BITS     = TABLE_BITS - 2;
    localparam int QUARTER      = 1 << QTR_BITS;

    // field widths
    localparam int PHASE_W    = 32;
    localparam int FREQ_W     = 23;
    localparam int FREQ_FRAC  = 8;
    localparam int AMP_W      = 16;
    localparam int SAMPLE_W   = 16;
    localparam int TVAL_W     = 17;
    localparam int MAG_W      = 16;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    // shared multiplier
    localparam int MUL_W      = 25;
    localparam int MUL_P_W    = 2 * MUL_W;
    localparam int HALF_W     = 24;
    localparam int PROD_W     = 34;

    // phase increment: floor(freq * 2^24 / SAMPLE_RATE) as (freq * INC_MUL) >> INC_FRAC
    localparam int INC_FRAC   = 32;
    localparam int INC_EXP    = PHASE_W - FREQ_FRAC + INC_FRAC;
    localparam logic [63:0] INC_MUL =
        ((64'd1 << INC_EXP) + 64'(SAMPLE_RATE) - 64'd1) / 64'(SAMPLE_RATE);
    localparam logic [HALF_W-1:0] INC_MUL_LO = INC_MUL[HALF_W-1:0];
    localparam logic [HALF_W-1:0] INC_MUL_HI = INC_MUL[2*HALF_W-1:HALF_W];
    localparam int INC_SUM_W  = 2 * HALF_W + 1;

    // output scaling
    localparam int FRAC_BITS  = 15;
    localparam int RSHIFT_W   = PROD_W - FRAC_BITS;
    localparam logic signed [PROD_W-1:0]   ROUND_BIAS = PROD_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [RSHIFT_W-1:0] SAT_HI     = RSHIFT_W'(32767);
    localparam logic signed [RSHIFT_W-1:0] SAT_LO     = -RSHIFT_W'(32768);
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
    localparam logic signed [TVAL_W-1:0]   TVAL_ONE   = 17'sd32768;
    localparam logic [TABLE_BITS-1:0]      HALF_IDX   = TABLE_BITS'(1) << (TABLE_BITS - 1);

    // reset values
    localparam logic [FREQ_W-1:0] FREQ_RESET = 23'd112640;
    localparam logic [AMP_W-1:0]  AMP_RESET  = 16'd32768;

    // register map
    localparam logic [1:0] REG_WAVEFORM  = 2'd0;
    localparam logic [1:0] REG_BASE_FREQ = 2'd1;
    localparam logic [1:0] REG_BASE_AMP  = 2'd2;

    typedef enum logic [1:0] {
        WAVE_SINE   = 2'd0,
        WAVE_SQUARE = 2'd1,
        WAVE_SAW    = 2'd2
    } wave_t;

    localparam logic [1:0] WAVE_RESERVED = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_PHASE,
        ST_LOOKUP,
        ST_MUL_AMP,
        ST_ROUND
    } state_t;

    typedef struct packed {
        wave_t             waveform;
        logic              freq_load;
        logic [FREQ_W-1:0] freq;
        logic              amp_load;
        logic [AMP_W-1:0]  amp;
    } cfg_t;

    typedef struct packed {
        logic load_track;
        logic mul_lo;
        logic mul_hi;
        logic step_phase;
        logic lookup;
        logic mul_amp;
        logic out_load;
    } cmd_t;

    // sine series in q30
    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [QUARTER-1:0][MAG_W-1:0] sine_rom_t;

    function automatic logic [MAG_W-1:0] sine_mag(input int unsigned k);
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        r  = 64'(k) << (16 - TABLE_BITS);
        x  = (r * HALF_PI_Q30) >> 14;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        return MAG_W'((s + 64'd16384) >> 15);
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int k = 0; k < QUARTER; k++)
        begin
            rom[k] = sine_mag(k);
        end
        return rom;
    endfunction

    localparam sine_rom_t        SINE_ROM  = build_sine_rom();
    localparam logic [MAG_W-1:0] SINE_PEAK = sine_mag(QUARTER);

endpackage

// File: design/wto_regs.sv
// ----------------------------------------------------------------------------
// wto_regs
// apb register bank: waveform select, base frequency and base amplitude
// ----------------------------------------------------------------------------
module wto_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wto_pkg::PADDR_W-1:0]   paddr,
    input  logic [wto_pkg::PDATA_W-1:0]   pwdata,
    output logic [wto_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output wto_pkg::cfg_t                 cfg
);

    wto_pkg::wave_t                    waveform_reg;
    wto_pkg::wave_t                    waveform_next;
    logic [wto_pkg::FREQ_W-1:0]        base_freq_reg;
    logic [wto_pkg::FREQ_W-1:0]        base_freq_next;
    logic [wto_pkg::AMP_W-1:0]         base_amp_reg;
    logic [wto_pkg::AMP_W-1:0]         base_amp_next;
    logic                              wr_en;
    logic [1:0]                        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        waveform_next  = waveform_reg;
        base_freq_next = base_freq_reg;
        base_amp_next  = base_amp_reg;
        cfg.waveform   = waveform_reg;
        cfg.freq       = pwdata[wto_pkg::FREQ_W-1:0];
        cfg.amp        = pwdata[wto_pkg::AMP_W-1:0];
        cfg.freq_load  = 1'b0;
        cfg.amp_load   = 1'b0;
        if (wr_en)
        begin
            unique case (reg_idx)
                wto_pkg::REG_WAVEFORM:
                begin
                    // reserved code leaves the selection as it was
                    if (pwdata[1:0] != wto_pkg::WAVE_RESERVED)
                    begin
                        waveform_next = wto_pkg::wave_t'(pwdata[1:0]);
                    end
                end
                wto_pkg::REG_BASE_FREQ:
                begin
                    base_freq_next = pwdata[wto_pkg::FREQ_W-1:0];
                    cfg.freq_load  = 1'b1;
                end
                wto_pkg::REG_BASE_AMP:
                begin
                    base_amp_next = pwdata[wto_pkg::AMP_W-1:0];
                    cfg.amp_load  = 1'b1;
                end
                default:
                begin
                    waveform_next = waveform_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            wto_pkg::REG_WAVEFORM:  prdata = {30'd0, waveform_reg};
            wto_pkg::REG_BASE_FREQ: prdata = {9'd0, base_freq_reg};
            wto_pkg::REG_BASE_AMP:  prdata = {16'd0, base_amp_reg};
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg  <= wto_pkg::WAVE_SINE;
            base_freq_reg <= wto_pkg::FREQ_RESET;
            base_amp_reg  <= wto_pkg::AMP_RESET;
        end
        else
        begin
            waveform_reg  <= waveform_next;
            base_freq_reg <= base_freq_next;
            base_amp_reg  <= base_amp_next;
        end
    end

endmodule

// File: design/wto_ctrl.sv
// ----------------------------------------------------------------------------
// wto_ctrl
// sequencer for one tick: increment, phase step, lookup, gain, round
// ----------------------------------------------------------------------------
module wto_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          tick_valid,
    output logic          tick_ready,
    output logic          sample_valid,
    input  logic          sample_ready,
    output wto_pkg::cmd_t cmd
);

    wto_pkg::state_t state_reg;
    wto_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || sample_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wto_pkg::ST_IDLE:
            begin
                if (tick_valid)
                begin
                    state_next = wto_pkg::ST_MUL_LO;
                end
            end
            wto_pkg::ST_MUL_LO:  state_next = wto_pkg::ST_MUL_HI;
            wto_pkg::ST_MUL_HI:  state_next = wto_pkg::ST_PHASE;
            wto_pkg::ST_PHASE:   state_next = wto_pkg::ST_LOOKUP;
            wto_pkg::ST_LOOKUP:  state_next = wto_pkg::ST_MUL_AMP;
            wto_pkg::ST_MUL_AMP: state_next = wto_pkg::ST_ROUND;
            wto_pkg::ST_ROUND:
            begin
                if (out_free)
                begin
                    state_next = wto_pkg::ST_IDLE;
                end
            end
            default:             state_next = wto_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        tick_ready = 1'b0;
        unique case (state_reg)
            wto_pkg::ST_IDLE:
            begin
                tick_ready     = 1'b1;
                cmd.load_track = tick_valid;
            end
            wto_pkg::ST_MUL_LO:  cmd.mul_lo     = 1'b1;
            wto_pkg::ST_MUL_HI:  cmd.mul_hi     = 1'b1;
            wto_pkg::ST_PHASE:   cmd.step_phase = 1'b1;
            wto_pkg::ST_LOOKUP:  cmd.lookup     = 1'b1;
            wto_pkg::ST_MUL_AMP: cmd.mul_amp    = 1'b1;
            wto_pkg::ST_ROUND:   cmd.out_load   = out_free;
            default:             tick_ready     = 1'b0;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (sample_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign sample_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wto_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: design/wto_datapath.sv
// ----------------------------------------------------------------------------
// wto_datapath
// working registers, phase accumulator, waveform lookup, shared multiplier
// and output rounding with saturation
// ----------------------------------------------------------------------------
module wto_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wto_pkg::cfg_t                       cfg,
    input  wto_pkg::cmd_t                       cmd,
    input  logic                                track_present,
    input  logic [wto_pkg::FREQ_W-1:0]          track_frequency,
    input  logic [wto_pkg::AMP_W-1:0]           track_amplitude,
    output logic signed [wto_pkg::SAMPLE_W-1:0] sample_out
);

    logic [wto_pkg::FREQ_W-1:0]           freq_reg;
    logic [wto_pkg::FREQ_W-1:0]           freq_next;
    logic [wto_pkg::AMP_W-1:0]            amp_reg;
    logic [wto_pkg::AMP_W-1:0]            amp_next;
    logic [wto_pkg::PHASE_W-1:0]          phase_reg;
    logic [wto_pkg::PHASE_W-1:0]          phase_next;
    logic [wto_pkg::HALF_W-1:0]           lo_reg;
    logic [wto_pkg::HALF_W-1:0]           lo_next;
    logic [wto_pkg::PHASE_W-1:0]          inc_reg;
    logic [wto_pkg::PHASE_W-1:0]          inc_next;
    logic signed [wto_pkg::TVAL_W-1:0]    tval_reg;
    logic signed [wto_pkg::TVAL_W-1:0]    tval_next;
    logic signed [wto_pkg::PROD_W-1:0]    prod_reg;
    logic signed [wto_pkg::PROD_W-1:0]    prod_next;
    logic signed [wto_pkg::SAMPLE_W-1:0]  sample_reg;
    logic signed [wto_pkg::SAMPLE_W-1:0]  sample_next;

    logic signed [wto_pkg::MUL_W-1:0]     mul_a;
    logic signed [wto_pkg::MUL_W-1:0]     mul_b;
    logic signed [wto_pkg::MUL_P_W-1:0]   mul_p;
    logic [wto_pkg::INC_SUM_W-1:0]        inc_sum;

    logic [wto_pkg::TABLE_BITS-1:0]       idx;
    logic [1:0]                           quad;
    logic [wto_pkg::QTR_BITS-1:0]         k0;
    logic [wto_pkg::QTR_BITS-1:0]         k_mirror;
    logic [wto_pkg::MAG_W-1:0]            sine_m;
    logic signed [wto_pkg::TVAL_W-1:0]    sine_v;
    logic signed [wto_pkg::TVAL_W-1:0]    square_v;
    logic [wto_pkg::MAG_W-1:0]            saw_u;
    logic signed [wto_pkg::TVAL_W-1:0]    saw_v;
    logic signed [wto_pkg::TVAL_W-1:0]    wave_v;

    logic signed [wto_pkg::PROD_W-1:0]    rsum;
    logic signed [wto_pkg::RSHIFT_W-1:0]  rshift;
    logic signed [wto_pkg::SAMPLE_W-1:0]  sat_v;

    // shared multiplier
    always_comb
    begin
        mul_a = {2'b00, freq_reg};
        mul_b = {1'b0, wto_pkg::INC_MUL_LO};
        if (cmd.mul_hi)
        begin
            mul_b = {1'b0, wto_pkg::INC_MUL_HI};
        end
        if (cmd.mul_amp)
        begin
            mul_a = {{(wto_pkg::MUL_W - wto_pkg::TVAL_W){tval_reg[wto_pkg::TVAL_W-1]}},
                     tval_reg};
            mul_b = {{(wto_pkg::MUL_W - wto_pkg::AMP_W){1'b0}}, amp_reg};
        end
    end

    assign mul_p = mul_a * mul_b;

    // increment from the two partial products
    assign inc_sum = {1'b0, mul_p[2*wto_pkg::HALF_W-1:0]}
                   + {{(wto_pkg::INC_SUM_W - wto_pkg::HALF_W){1'b0}}, lo_reg};

    // waveform lookup
    assign idx      = phase_reg[wto_pkg::PHASE_W-1 -: wto_pkg::TABLE_BITS];
    assign quad     = idx[wto_pkg::TABLE_BITS-1 -: 2];
    assign k0       = idx[wto_pkg::QTR_BITS-1:0];
    assign k_mirror = ~k0 + {{(wto_pkg::QTR_BITS-1){1'b0}}, 1'b1};

    always_comb
    begin
        if (!quad[0])
        begin
            sine_m = wto_pkg::SINE_ROM[k0];
        end
        else if (k0 == '0)
        begin
            sine_m = wto_pkg::SINE_PEAK;
        end
        else
        begin
            sine_m = wto_pkg::SINE_ROM[k_mirror];
        end
    end

    assign sine_v   = quad[1] ? -$signed({1'b0, sine_m}) : $signed({1'b0, sine_m});
    assign square_v = (idx <= wto_pkg::HALF_IDX) ? wto_pkg::TVAL_ONE : -wto_pkg::TVAL_ONE;
    assign saw_u    = wto_pkg::MAG_W'(idx) << (wto_pkg::MAG_W - wto_pkg::TABLE_BITS);
    assign saw_v    = $signed({1'b0, saw_u}) - wto_pkg::TVAL_ONE;

    always_comb
    begin
        case (cfg.waveform)
            wto_pkg::WAVE_SQUARE: wave_v = square_v;
            wto_pkg::WAVE_SAW:    wave_v = saw_v;
            default:              wave_v = sine_v;
        endcase
    end

    // round to nearest, then clamp
    assign rsum   = prod_reg + wto_pkg::ROUND_BIAS;
    assign rshift = rsum[wto_pkg::PROD_W-1:wto_pkg::FRAC_BITS];

    always_comb
    begin
        if (rshift > wto_pkg::SAT_HI)
        begin
            sat_v = wto_pkg::SAMPLE_MAX;
        end
        else if (rshift < wto_pkg::SAT_LO)
        begin
            sat_v = wto_pkg::SAMPLE_MIN;
        end
        else
        begin
            sat_v = rshift[wto_pkg::SAMPLE_W-1:0];
        end
    end

    // next values
    always_comb
    begin
        freq_next = freq_reg;
        amp_next  = amp_reg;
        if (cfg.freq_load)
        begin
            freq_next = cfg.freq;
        end
        else if (cmd.load_track && track_present)
        begin
            freq_next = track_frequency;
        end
        if (cfg.amp_load)
        begin
            amp_next = cfg.amp;
        end
        else if (cmd.load_track && track_present)
        begin
            amp_next = track_amplitude;
        end
    end

    assign phase_next  = cmd.step_phase ? phase_reg + inc_reg : phase_reg;
    assign lo_next     = cmd.mul_lo ? mul_p[2*wto_pkg::HALF_W-1:wto_pkg::HALF_W] : lo_reg;
    assign inc_next    = cmd.mul_hi
                       ? inc_sum[wto_pkg::INC_FRAC - wto_pkg::HALF_W +: wto_pkg::PHASE_W]
                       : inc_reg;
    assign tval_next   = cmd.lookup ? wave_v : tval_reg;
    assign prod_next   = cmd.mul_amp ? mul_p[wto_pkg::PROD_W-1:0] : prod_reg;
    assign sample_next = cmd.out_load ? sat_v : sample_reg;

    assign sample_out = sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg  <= wto_pkg::FREQ_RESET;
            amp_reg   <= wto_pkg::AMP_RESET;
            phase_reg <= '0;
        end
        else
        begin
            freq_reg  <= freq_next;
            amp_reg   <= amp_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        inc_reg    <= inc_next;
        tval_reg   <= tval_next;
        prod_reg   <= prod_next;
        sample_reg <= sample_next;
    end

endmodule

// File: design/wavetable_oscillator_top.sv
// ----------------------------------------------------------------------------
// wavetable_oscillator_top
// wavetable oscillator: phase accumulator indexing sine, square or saw,
// scaled by a working amplitude, one sample per tick item
//
//   channel   signals                                        direction
//   apb       psel penable pwrite paddr pwdata prdata pready  config in
//   tick      tick_valid tick_ready track_*                  item in
//   sample    sample_valid sample_ready sample_out           item out
//
// tick items are taken one at a time by the sequencer stepping through the
// shared 25x25 multiplier (two increment partial products, then the gain)
// one item in flight; the next is taken while a sample waits in the output
// register, a stalled sample holds only the final rounding step
// reset: phase zero, working frequency 440 hz, amplitude 1.0, sine selected
// ----------------------------------------------------------------------------
module wavetable_oscillator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wto_pkg::PADDR_W-1:0]         paddr,
    input  logic [wto_pkg::PDATA_W-1:0]         pwdata,
    output logic [wto_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                tick_valid,
    output logic                                tick_ready,
    input  logic                                track_present,
    input  logic [wto_pkg::FREQ_W-1:0]          track_frequency,
    input  logic [wto_pkg::AMP_W-1:0]           track_amplitude,
    output logic                                sample_valid,
    input  logic                                sample_ready,
    output logic signed [wto_pkg::SAMPLE_W-1:0] sample_out
);

    wto_pkg::cfg_t cfg;
    wto_pkg::cmd_t cmd;

    wto_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wto_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .cmd          (cmd)
    );

    wto_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd             (cmd),
        .track_present   (track_present),
        .track_frequency (track_frequency),
        .track_amplitude (track_amplitude),
        .sample_out      (sample_out)
    );

    // a taken tick keeps the input closed while it is worked on
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> !tick_ready)
        else $error("tick taken while previous item in progress");

    // a rising sample valid is traced back to its accepted tick
    a_sample_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sample_valid) |-> $past(tick_valid && tick_ready, 7))
        else $error("sample appeared without matching tick");

    // no undelivered sample is overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!sample_valid || sample_ready))
        else $error("output register overwritten before delivery");

endmodule
